### src/bpa_pkg.sv
package bpa_pkg;

  localparam int MAX_PAGES = 4096;
  localparam int PAGE_BITS = 12;

  localparam int ADDR_W    = 48;
  localparam int CNT_W     = 13;
  localparam int PCT_W     = 7;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam int WORD_W    = 64;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int MAP_WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int WIDX_W    = $clog2(MAP_WORDS);
  localparam int NW_W      = WIDX_W + 1;
  localparam int IDX_W     = $clog2(MAX_PAGES);
  localparam int PROD_W    = CNT_W + PCT_W + 1;

  localparam logic [ADDR_W-1:0] BASE_RST  = ADDR_W'(64'h100_0000);
  localparam logic [CNT_W-1:0]  PAGES_RST = CNT_W'(4096);
  localparam logic [PCT_W-1:0]  PCT_RST   = PCT_W'(90);
  localparam logic [PCT_W-1:0]  PCT_SCALE = PCT_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 2'd0,
    CFG_PAGES = 2'd1,
    CFG_PCT   = 2'd2
  } cfg_reg_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOT_USED = 2'd3
  } req_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREE_CHK,
    S_FREE_RD,
    S_FREE_UPD,
    S_CALC,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load_req;
    logic scan_start;
    logic scan_step;
    logic alloc_commit;
    logic alloc_oom;
    logic free_check;
    logic free_read;
    logic free_range;
    logic free_update;
    logic calc;
    logic out_load;
  } bpa_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic range_err;
    logic out_busy;
  } bpa_stat_t;

endpackage

### src/bpa_ram.sv
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/bpa_ctrl.sv
module bpa_ctrl import bpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_req_type,
  input  bpa_stat_t stat,
  output logic      in_stall,
  output bpa_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_req_type ? S_FREE_CHK : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit || stat.scan_end) begin
          state_nxt = S_CALC;
        end
      end
      S_FREE_CHK: state_nxt = S_FREE_RD;
      S_FREE_RD:  state_nxt = stat.range_err ? S_CALC : S_FREE_UPD;
      S_FREE_UPD: state_nxt = S_CALC;
      S_CALC:     state_nxt = S_DONE;
      S_DONE: begin
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req   = 1'b1;
          cmd.scan_start = !in_req_type;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.alloc_commit = 1'b1;
        end else if (stat.scan_end) begin
          cmd.alloc_oom = 1'b1;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FREE_CHK: cmd.free_check = 1'b1;
      S_FREE_RD: begin
        if (stat.range_err) begin
          cmd.free_range = 1'b1;
        end else begin
          cmd.free_read = 1'b1;
        end
      end
      S_FREE_UPD: cmd.free_update = 1'b1;
      S_CALC:     cmd.calc = 1'b1;
      S_DONE:     cmd.out_load = !stat.out_busy;
      default:    cmd = '0;
    endcase
  end

endmodule

### src/bpa_dp.sv
module bpa_dp import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] in_page_addr,
  input  logic              cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0] cfg_wdata,
  input  logic              out_stall,
  input  bpa_cmd_t          cmd,
  output bpa_stat_t         stat,
  output logic              out_valid,
  output logic [ADDR_W-1:0] out_alloc_addr,
  output logic [STAT_W-1:0] out_status,
  output logic [CNT_W-1:0]  out_used_count,
  output logic              out_under_pressure
);

  // config
  logic [ADDR_W-1:0] base_r;
  logic [CNT_W-1:0]  total_r;
  logic [PCT_W-1:0]  pct_r;
  logic              clr_map;

  // map state
  logic [MAP_WORDS-1:0] row_vld_r;
  logic [CNT_W-1:0]     used_r, used_nxt;

  // request
  logic [ADDR_W-1:0] addr_r;
  logic [IDX_W-1:0]  idx_r;
  logic              hit_r;
  logic              range_err_r;
  logic [STAT_W-1:0] status_r;

  // scan
  logic [NW_W-1:0]   rd_w_r;
  logic [WIDX_W-1:0] chk_w_r;
  logic              chk_vld_r;
  logic              rvld_r;

  // pressure
  logic [PROD_W-1:0] prod_used_r, prod_lim_r;
  logic              nz_r;
  logic [ADDR_W-1:0] res_addr_r;

  // output register
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [STAT_W-1:0] out_status_r;
  logic [CNT_W-1:0]  out_used_r;
  logic              out_press_r;

  logic [CNT_W-1:0]  n_pages;
  logic [NW_W-1:0]   n_words;
  logic [NW_W-1:0]   n_hi;
  logic [CNT_W:0]    n_round;

  logic              ram_we, ram_re;
  logic [WIDX_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [WORD_W-1:0] word, lim_mask, free_bits;
  logic [BIT_W-1:0]  bit_sel;
  logic [WORD_W-1:0] bit_oh;

  logic [ADDR_W-1:0] diff;
  logic [ADDR_W-PAGE_BITS-1:0] diff_page;
  logic              free_err;

  assign clr_map = cfg_we && (cfg_index == CFG_PAGES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BASE_RST;
      total_r <= PAGES_RST;
      pct_r   <= PCT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE:  base_r  <= cfg_wdata;
        CFG_PAGES: total_r <= cfg_wdata[CNT_W-1:0];
        CFG_PCT:   pct_r   <= cfg_wdata[PCT_W-1:0];
        default:   ;
      endcase
    end
  end

  assign n_pages = (total_r > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : total_r;
  assign n_round = {1'b0, n_pages} + (CNT_W+1)'(WORD_W - 1);
  assign n_words = NW_W'(n_round >> BIT_W);
  assign n_hi    = NW_W'(n_pages >> BIT_W);

  // current map word, rows never written read as all free
  assign word     = rvld_r ? ram_rdata : '0;
  assign lim_mask = ({1'b0, chk_w_r} < n_hi) ? {WORD_W{1'b1}}
                  : ((WORD_W'(1) << n_pages[BIT_W-1:0]) - WORD_W'(1));
  assign free_bits = ~word & lim_mask;

  always_comb begin
    bit_sel = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        bit_sel = BIT_W'(b);
      end
    end
  end

  assign bit_oh = WORD_W'(1) << (cmd.alloc_commit ? bit_sel : idx_r[BIT_W-1:0]);

  assign stat.hit       = chk_vld_r && (|free_bits);
  assign stat.scan_end  = !chk_vld_r && (rd_w_r >= n_words);
  assign stat.range_err = range_err_r;
  assign stat.out_busy  = out_valid_r && out_stall;

  // map RAM ports
  always_comb begin
    ram_re    = cmd.scan_step || cmd.free_read;
    ram_raddr = cmd.free_read ? idx_r[IDX_W-1:BIT_W] : rd_w_r[WIDX_W-1:0];
    ram_we    = cmd.alloc_commit || (cmd.free_update && word[idx_r[BIT_W-1:0]]);
    ram_waddr = cmd.alloc_commit ? chk_w_r : idx_r[IDX_W-1:BIT_W];
    ram_wdata = cmd.alloc_commit ? (word | bit_oh) : (word & ~bit_oh);
  end

  bpa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || clr_map) begin
      row_vld_r <= '0;
    end else if (ram_we) begin
      row_vld_r[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rvld_r <= row_vld_r[ram_raddr];
    end
  end

  always_comb begin
    used_nxt = used_r;
    if (cmd.alloc_commit) begin
      used_nxt = used_r + CNT_W'(1);
    end else if (cmd.free_update && word[idx_r[BIT_W-1:0]]) begin
      used_nxt = used_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr_map) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // scan counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_w_r    <= '0;
      chk_vld_r <= 1'b0;
    end else if (cmd.scan_start) begin
      rd_w_r    <= '0;
      chk_vld_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (rd_w_r < n_words) begin
        rd_w_r    <= rd_w_r + NW_W'(1);
        chk_vld_r <= 1'b1;
      end else begin
        chk_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      chk_w_r <= rd_w_r[WIDX_W-1:0];
    end
  end

  // free address check
  assign diff      = addr_r - base_r;
  assign diff_page = diff[ADDR_W-1:PAGE_BITS];
  assign free_err  = (addr_r < base_r)
                   || (diff_page >= (ADDR_W-PAGE_BITS)'(n_pages));

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      addr_r      <= in_page_addr;
      hit_r       <= 1'b0;
      range_err_r <= 1'b0;
      status_r    <= ST_OK;
    end
    if (cmd.free_check) begin
      idx_r       <= diff_page[IDX_W-1:0];
      range_err_r <= free_err;
    end
    if (cmd.alloc_commit) begin
      idx_r <= {chk_w_r, bit_sel};
      hit_r <= 1'b1;
    end
    if (cmd.alloc_oom) begin
      status_r <= ST_OOM;
    end
    if (cmd.free_range) begin
      status_r <= ST_RANGE;
    end
    if (cmd.free_update && !word[idx_r[BIT_W-1:0]]) begin
      status_r <= ST_NOT_USED;
    end
  end

  // pressure: used*100 >= (pct+1)*n  <=>  floor(used*100/n) > pct
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      prod_used_r <= PROD_W'(used_r) * PROD_W'(PCT_SCALE);
      prod_lim_r  <= PROD_W'({1'b0, pct_r} + (PCT_W+1)'(1)) * PROD_W'(n_pages);
      nz_r        <= (n_pages != '0);
      res_addr_r  <= hit_r ? (base_r + (ADDR_W'(idx_r) << PAGE_BITS)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= status_r;
      out_used_r   <= used_r;
      out_press_r  <= nz_r && (prod_used_r >= prod_lim_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_alloc_addr     = out_addr_r;
  assign out_status         = out_status_r;
  assign out_used_count     = out_used_r;
  assign out_under_pressure = out_press_r;

endmodule

### src/bitmap_page_allocator_top.sv
// Channel | Direction | Ports                                   | Handshake
// in      | input     | in_req_type, in_page_addr               | in_valid / in_stall
// out     | output    | out_alloc_addr, out_status,             | out_valid / out_stall
//         |           | out_used_count, out_under_pressure      |
// cfg     | input     | cfg_index, cfg_wdata                    | cfg_we (no wait)
//
// One request at a time. A free checks the range, then reads the map word and
// clears the page's bit unless out of range. An allocate reads one 64-bit map word
// per cycle up to the first word with a free page, or through all ceil(pages/64)
// words to report out of memory. Reset (rst_n low, synchronous) and a page count
// write clear the map at once through per-row valid flops. A stalled result holds the
// output register while the next request runs; only its final load waits.
module bitmap_page_allocator_top import bpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_req_type,
  input  logic [ADDR_W-1:0]    in_page_addr,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_W-1:0]    out_alloc_addr,
  output logic [STAT_W-1:0]    out_status,
  output logic [CNT_W-1:0]     out_used_count,
  output logic                 out_under_pressure,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

  bpa_cmd_t  cmd;
  bpa_stat_t stat;

  // sequencer: dispatch, scan control, free steps, result handoff
  bpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req_type(in_req_type),
    .stat       (stat),
    .in_stall   (in_stall),
    .cmd        (cmd)
  );

  // map RAM, counters, address math, pressure compare, output register
  bpa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_page_addr      (in_page_addr),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_stall         (out_stall),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_alloc_addr    (out_alloc_addr),
    .out_status        (out_status),
    .out_used_count    (out_used_count),
    .out_under_pressure(out_under_pressure)
  );

endmodule

### tb/sv/bitmap_page_allocator_top_test.sv
// Testbench for the bitmap page frame allocator.
// A directed table runs first. Then come random bursts of alloc and free requests,
// each burst after random register writes. Every accepted request is run
// through a mirror of the page map, and the result it predicts is queued.
// Results are then checked in order against that queue.
module bitmap_page_allocator_top_test;
  import bpa_pkg::*;

  // request type encoding on in_req_type
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam int RANDOM_ITEMS = 1625;
  // no handshake on either side for this many cycles means the block hung;
  // worst legal gap is a sender gap plus a full-map scan plus a receiver stall
  localparam int STALL_LIMIT  = 2000;
  // drain time after the last result
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [ADDR_W-1:0] alloc_addr;
    req_status_t       status;
    logic [CNT_W-1:0]  used_count;
    logic              under_pressure;
  } page_result_t;

  typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

  // one row of the directed table: a request or a register write
  typedef struct {
    row_kind_t         kind;
    logic              op;
    cfg_reg_t          reg_sel;
    logic [ADDR_W-1:0] value;
    bit                pinned;   // want holds a hand-written result
    page_result_t      want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_req_type = REQ_ALLOC;
  logic [ADDR_W-1:0]    in_page_addr = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ADDR_W-1:0]    out_alloc_addr;
  logic [STAT_W-1:0]    out_status;
  logic [CNT_W-1:0]     out_used_count;
  logic                 out_under_pressure;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE;
  logic [ADDR_W-1:0]    cfg_wdata = '0;

  // mirror of the block: registers, page map and used count
  logic [ADDR_W-1:0] mirror_base  = BASE_RST;
  logic [CNT_W-1:0]  mirror_pages = PAGES_RST;
  logic [PCT_W-1:0]  mirror_pct   = PCT_RST;
  bit                mirror_map [MAX_PAGES];
  int                mirror_used = 0;

  page_result_t pending_results[$];
  plan_row_t    plan[$];
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  int           send_idle_pct = 10;
  int           recv_stall_pct = 57;

  bitmap_page_allocator_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_page_addr       (in_page_addr),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_alloc_addr     (out_alloc_addr),
    .out_status         (out_status),
    .out_used_count     (out_used_count),
    .out_under_pressure (out_under_pressure),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] rand48();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // a page count above the map size manages the whole map
  function automatic int pages_in_use();
    return (mirror_pages > MAX_PAGES) ? MAX_PAGES : int'(mirror_pages);
  endfunction

  // Apply one request to the mirror and return the result the block owes.
  function automatic page_result_t predict_page_result(logic op, logic [ADDR_W-1:0] addr);
    page_result_t      res;
    int                n;
    int                pick;
    logic [ADDR_W-1:0] page;
    n = pages_in_use();
    res = '0;
    res.status = ST_OK;
    if (op == REQ_ALLOC) begin
      // first fit: lowest free page below the page count
      pick = 0;
      while (pick < n && mirror_map[pick]) pick++;
      if (pick < n) begin
        mirror_map[pick] = 1'b1;
        mirror_used++;
        // the sum wraps at 48 bits
        res.alloc_addr = mirror_base + (ADDR_W'(pick) << PAGE_BITS);
      end else begin
        res.status = ST_OOM;
      end
    end else if (addr < mirror_base) begin
      res.status = ST_RANGE;
    end else begin
      // offset bits below the page size are dropped
      page = (addr - mirror_base) >> PAGE_BITS;
      if (page >= ADDR_W'(n)) begin
        res.status = ST_RANGE;
      end else if (!mirror_map[page]) begin
        res.status = ST_NOT_USED;
      end else begin
        mirror_map[page] = 1'b0;
        mirror_used--;
      end
    end
    res.used_count = CNT_W'(mirror_used);
    res.under_pressure = (n != 0) && (mirror_used * int'(PCT_SCALE) / n > int'(mirror_pct));
    return res;
  endfunction

  task automatic add_cfg(cfg_reg_t r, logic [ADDR_W-1:0] v);
    plan.push_back('{kind: ROW_CFG, op: REQ_ALLOC, reg_sel: r, value: v,
                     pinned: 1'b0, want: '0});
  endtask

  task automatic add_req(logic op, logic [ADDR_W-1:0] a);
    plan.push_back('{kind: ROW_REQ, op: op, reg_sel: CFG_BASE, value: a,
                     pinned: 1'b0, want: '0});
  endtask

  task automatic add_pinned(logic op, logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] ea,
                            req_status_t es, int eu, logic ep);
    page_result_t w;
    w.alloc_addr = ea;
    w.status = es;
    w.used_count = CNT_W'(eu);
    w.under_pressure = ep;
    plan.push_back('{kind: ROW_REQ, op: op, reg_sel: CFG_BASE, value: a,
                     pinned: 1'b1, want: w});
  endtask

  // Drop in_valid and wait until every owed result has been taken.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Offer one request, hold it through stalls, and queue its result once taken.
  // in_valid stays high on exit so back-to-back requests need no extra edge.
  task automatic send_request(logic op, logic [ADDR_W-1:0] a, bit pinned,
                              page_result_t want);
    page_result_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= op;
    in_page_addr <= a;
    do @(posedge clk); while (in_stall);
    got = predict_page_result(op, a);
    pending_results.push_back(pinned ? want : got);
  endtask

  // Register writes only go in while the block is idle.
  task automatic write_reg(cfg_reg_t r, logic [ADDR_W-1:0] v);
    quiesce();
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      CFG_BASE:  mirror_base = v;
      CFG_PAGES: begin
        // a page count write clears the whole map
        mirror_pages = v[CNT_W-1:0];
        mirror_used = 0;
        foreach (mirror_map[i]) mirror_map[i] = 1'b0;
      end
      CFG_PCT:   mirror_pct = v[PCT_W-1:0];
      default:   ;
    endcase
    @(posedge clk);
  endtask

  // Mostly allocs and frees of live pages. The rest are frees that are likely to be
  // rejected: random addresses, one below base, one past the last page, and
  // pages that may already be free.
  task automatic send_random_request(int alloc_pct);
    int                n;
    int                r;
    int                page;
    int                off;
    logic [ADDR_W-1:0] a;
    n = pages_in_use();
    r = $urandom_range(99);
    a = rand48();   // random address bits on allocs too; they must be ignored
    if (r < alloc_pct) begin
      send_request(REQ_ALLOC, a, 1'b0, '0);
    end else begin
      off = $urandom_range(1) ? $urandom_range((1 << PAGE_BITS) - 1) : 0;
      if (r < 90 && mirror_used != 0) begin
        page = $urandom_range(n - 1);
        while (!mirror_map[page]) page = (page + 1) % n;
        a = mirror_base + (ADDR_W'(page) << PAGE_BITS) + ADDR_W'(off);
      end else begin
        case ($urandom_range(3))
          0: ;
          1: a = mirror_base - 1;
          2: a = mirror_base + (ADDR_W'(n) << PAGE_BITS);
          default: a = mirror_base + (ADDR_W'($urandom_range(n)) << PAGE_BITS) + ADDR_W'(off);
        endcase
      end
      send_request(REQ_FREE, a, 1'b0, '0);
    end
  endtask

  task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: random stall, its rate set by the current idle mode.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result checker: each accepted result against the oldest owed one.
  always @(posedge clk) begin
    page_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d, used %0d",
               out_status, out_used_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("alloc_addr", want.alloc_addr, out_alloc_addr);
        check_field("status", ADDR_W'(want.status), ADDR_W'(out_status));
        check_field("used_count", ADDR_W'(want.used_count), ADDR_W'(out_used_count));
        check_field("under_pressure", ADDR_W'(want.under_pressure),
                    ADDR_W'(out_under_pressure));
      end
    end
  end

  // Watchdog: a long run of cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int  sent;
    int  n;
    int  r;
    int  burst;
    int  alloc_pct;
    bit  fill;
    logic [ADDR_W-1:0] v;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed table ---
    // after reset: base 0x1000000, 4096 pages, threshold 90
    add_pinned(REQ_ALLOC, '0, 48'h100_0000, ST_OK, 1, 1'b0);
    add_pinned(REQ_ALLOC, '1, 48'h100_1000, ST_OK, 2, 1'b0);
    add_pinned(REQ_FREE, 48'h100_0000, '0, ST_OK, 1, 1'b0);
    add_pinned(REQ_FREE, 48'h100_0000, '0, ST_NOT_USED, 1, 1'b0);   // double free
    add_pinned(REQ_FREE, 48'h0, '0, ST_RANGE, 1, 1'b0);             // below base
    add_pinned(REQ_FREE, 48'h200_0000, '0, ST_RANGE, 1, 1'b0);      // first page past the end
    add_pinned(REQ_FREE, '1, '0, ST_RANGE, 1, 1'b0);
    add_pinned(REQ_FREE, 48'h100_1FFF, '0, ST_OK, 0, 1'b0);         // unaligned frees page 1
    add_pinned(REQ_ALLOC, '0, 48'h100_0000, ST_OK, 1, 1'b0);
    // no pages: alloc runs out, every free is out of range
    add_cfg(CFG_PAGES, 48'd0);
    add_pinned(REQ_ALLOC, '0, '0, ST_OOM, 0, 1'b0);
    add_pinned(REQ_FREE, 48'h100_0000, '0, ST_RANGE, 0, 1'b0);
    // two pages, zero threshold: pressure as soon as anything is used
    add_cfg(CFG_PAGES, 48'd2);
    add_cfg(CFG_PCT, 48'd0);
    add_pinned(REQ_ALLOC, '0, 48'h100_0000, ST_OK, 1, 1'b1);
    add_pinned(REQ_ALLOC, '0, 48'h100_1000, ST_OK, 2, 1'b1);
    add_pinned(REQ_ALLOC, '0, '0, ST_OOM, 2, 1'b1);
    add_pinned(REQ_FREE, 48'h100_1000, '0, ST_OK, 1, 1'b1);
    // last page of the address space: the second page wraps to zero, and a
    // wrapped page sits below base so it cannot be freed
    add_cfg(CFG_BASE, 48'hFFFF_FFFF_F000);
    add_cfg(CFG_PAGES, 48'd3);
    add_cfg(CFG_PCT, 48'd100);
    add_req(REQ_ALLOC, '0);
    add_req(REQ_ALLOC, '0);
    add_req(REQ_ALLOC, '0);
    add_req(REQ_FREE, 48'h0);
    add_req(REQ_FREE, 48'hFFFF_FFFF_F000);
    // page count above the map size, threshold above 100
    add_cfg(CFG_BASE, 48'h0);
    add_cfg(CFG_PAGES, ADDR_W'((1 << CNT_W) - 1));
    add_cfg(CFG_PCT, ADDR_W'((1 << PCT_W) - 1));
    add_pinned(REQ_ALLOC, '1, 48'h0, ST_OK, 1, 1'b0);
    add_pinned(REQ_FREE, 48'h100_0000, '0, ST_RANGE, 1, 1'b0);
    add_pinned(REQ_FREE, 48'h0FFF, '0, ST_OK, 0, 1'b0);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        write_reg(plan[k].reg_sel, plan[k].value);
      end else begin
        send_request(plan[k].op, plan[k].value, plan[k].pinned, plan[k].want);
      end
    end

    // --- random bursts, each after random register writes ---
    // idle modes: sender light / receiver heavy, then swapped, then none
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (sent >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 57;
        recv_stall_pct = 10;
      end
      // now and then a burst that fills a mid-size map, for deep scans
      fill = ($urandom_range(9) == 0);

      if ($urandom_range(2) != 0) begin
        case ($urandom_range(3))
          0: v = '0;
          1: begin
            v = rand48();
            v[PAGE_BITS-1:0] = '0;
          end
          2: v = rand48();   // unaligned base
          default: v = {{(ADDR_W - PAGE_BITS){1'b1}}, {PAGE_BITS{1'b0}}}
                       - (ADDR_W'($urandom_range(16)) << PAGE_BITS);
        endcase
        write_reg(CFG_BASE, v);
      end

      if (fill) begin
        write_reg(CFG_PAGES, ADDR_W'($urandom_range(100, 400)));
      end else if ($urandom_range(2) != 0) begin
        r = $urandom_range(99);
        // mostly small maps so they fill up and run out
        if (r < 60) n = $urandom_range(1, 70);
        else if (r < 85) n = $urandom_range(71, 700);
        else if (r < 90) n = 0;
        else if (r < 95) n = MAX_PAGES;
        else n = $urandom_range(MAX_PAGES + 1, (1 << CNT_W) - 1);
        write_reg(CFG_PAGES, ADDR_W'(n));
      end

      if ($urandom_range(2) != 0) begin
        if ($urandom_range(4) != 0) begin
          write_reg(CFG_PCT, ADDR_W'($urandom_range(0, 100)));
        end else begin
          write_reg(CFG_PCT, ADDR_W'($urandom_range(101, (1 << PCT_W) - 1)));
        end
      end

      n = pages_in_use();
      if (fill) begin
        burst = n + n / 8 + 8;
        alloc_pct = 95;
      end else begin
        burst = (n > 700) ? 40 : $urandom_range(30, 90);
        alloc_pct = $urandom_range(40, 90);
      end
      // the last burst stops at the request budget
      if (burst > RANDOM_ITEMS - sent) burst = RANDOM_ITEMS - sent;
      repeat (burst) send_random_request(alloc_pct);
      sent += burst;
    end

    quiesce();
    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
